/* rtl/core/mst_pkg.sv */
package mst_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_JAB   = 2'd3;

  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 32;

  typedef struct packed {
    logic [1:0]          op;
    logic [SLOT_W-1:0]   slot;
    logic                periodic;
    logic                infinite;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

endpackage

/* rtl/core/multi_slot_software_timer.sv */
// Channel   Handshake        Ports
// request   start / busy     operation, slot, periodic, infinite, period_ticks
// result    strobe           fired_slot, last_fire
//
// A start, stop or jab is executed in the idle state. A tick scans the
// slots one per cycle through the deadline memory, with an extra advance
// state for each slot whose deadline needs a second step, then a flush state.
// A two-entry request queue accepts new requests while a tick is being
// scanned; busy is high only while that queue is full. Reset is synchronous
// and clears time, all slot marks and the queue. Results cannot be stalled.
module multi_slot_software_timer import mst_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation,
  input  logic [SLOT_W-1:0]   slot,
  input  logic                periodic,
  input  logic                infinite,
  input  logic [PERIOD_W-1:0] period_ticks,
  output logic                strobe,
  output logic [SLOT_W-1:0]   fired_slot,
  output logic                last_fire
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  mst_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .slot        (slot),
    .periodic    (periodic),
    .infinite    (infinite),
    .period_ticks(period_ticks),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  mst_back #(
    .NUM_SLOTS(NUM_SLOTS),
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .strobe    (strobe),
    .fired_slot(fired_slot),
    .last_fire (last_fire)
  );

endmodule

/* rtl/core/mst_front.sv */
module mst_front import mst_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation,
  input  logic [SLOT_W-1:0]   slot,
  input  logic                periodic,
  input  logic                infinite,
  input  logic [PERIOD_W-1:0] period_ticks,
  output logic                cmd_valid,
  output cmd_t                cmd,
  input  logic                cmd_pop
);

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       in_range;
  logic       push;

  // Requests that name a slot beyond the table are accepted and dropped here.
  assign in_range  = (operation == OP_TICK) ||
                     ({{(32-SLOT_W){1'b0}}, slot} < 32'(NUM_SLOTS));
  assign busy      = (count == 2'd2);
  assign accept    = start && !busy;
  assign push      = accept && in_range;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{op: operation, slot: slot, periodic: periodic,
                         infinite: infinite, period: period_ticks};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/mst_back.sv */
module mst_back import mst_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              strobe,
  output logic [SLOT_W-1:0] fired_slot,
  output logic              last_fire
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_ADV   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t                state;
  logic [IW-1:0]         idx;
  logic [TIME_BITS-1:0]  current_time;
  logic [TIME_BITS-1:0]  last_check;
  logic [NUM_SLOTS-1:0]  sched;
  logic [NUM_SLOTS-1:0]  per;
  logic [NUM_SLOTS-1:0]  inf;
  logic [NUM_SLOTS-1:0]  jab;
  logic                  pend_valid;
  logic [IW-1:0]         pend_slot;
  logic [TIME_BITS-1:0]  work;

  logic [TIME_BITS-1:0]  deadline_mem [NUM_SLOTS];
  logic [PERIOD_W-1:0]   period_mem [NUM_SLOTS];
  logic [TIME_BITS-1:0]  rd_deadline;
  logic [PERIOD_W-1:0]   rd_period;
  logic [IW-1:0]         rd_addr;

  logic [IW-1:0]         cmd_idx;
  logic [TIME_BITS-1:0]  step_p;
  logic [TIME_BITS-1:0]  adv1;
  logic                  hit;
  logic                  keep;
  logic                  step;
  logic                  again;
  logic [IW-1:0]         idx_inc;

  function automatic logic in_window(input logic [TIME_BITS-1:0] t,
                                     input logic [TIME_BITS-1:0] lo,
                                     input logic [TIME_BITS-1:0] hi);
    if (hi > lo) begin
      return (t >= lo) && (t <= hi);
    end
    return (t >= lo) || (t <= hi);
  endfunction

  assign cmd_idx = IW'(cmd.slot);
  assign step_p  = TIME_BITS'(rd_period);
  assign adv1    = rd_deadline + step_p;
  assign hit     = sched[idx] &&
                   (jab[idx] || (!inf[idx] &&
                    in_window(rd_deadline, last_check, current_time)));
  assign keep    = per[idx] && (rd_period != '0);
  assign step    = keep && !inf[idx] && (step_p != '0);
  // The window spans two ticks, so a second step always leaves it.
  assign again   = in_window(adv1, last_check, current_time);
  assign idx_inc = (idx == LAST_IDX) ? '0 : idx + IW'(1);
  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  // The read address points at the slot to be evaluated next, so the deadline and period of
  // the slot under scan are already registered when it is evaluated.
  always_comb begin
    case (state)
      S_IDLE:  rd_addr = '0;
      S_SCAN:  rd_addr = (hit && step && again) ? idx : idx_inc;
      S_ADV:   rd_addr = idx_inc;
      S_FLUSH: rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_deadline <= deadline_mem[rd_addr];
    rd_period   <= period_mem[rd_addr];
    if (cmd_pop && (cmd.op == OP_START)) begin
      deadline_mem[cmd_idx] <= current_time + TIME_BITS'(cmd.period);
      period_mem[cmd_idx]   <= cmd.period;
    end else if ((state == S_SCAN) && hit && step && !again) begin
      deadline_mem[idx] <= adv1;
    end else if (state == S_ADV) begin
      deadline_mem[idx] <= work + step_p;
    end
  end

  always_ff @(posedge clk) begin
    work <= adv1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      current_time <= '0;
      last_check   <= '0;
      sched        <= '0;
      per          <= '0;
      inf          <= '0;
      jab          <= '0;
      pend_valid   <= 1'b0;
      pend_slot    <= '0;
      strobe       <= 1'b0;
      fired_slot   <= '0;
      last_fire    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_TICK: begin
                current_time <= current_time + TIME_BITS'(1);
                idx          <= '0;
                state        <= S_SCAN;
              end
              OP_START: begin
                sched[cmd_idx] <= 1'b1;
                per[cmd_idx]   <= cmd.periodic;
                inf[cmd_idx]   <= cmd.infinite;
                jab[cmd_idx]   <= 1'b0;
              end
              OP_STOP: begin
                sched[cmd_idx] <= 1'b0;
                per[cmd_idx]   <= 1'b0;
                inf[cmd_idx]   <= 1'b0;
                jab[cmd_idx]   <= 1'b0;
              end
              OP_JAB: begin
                if (sched[cmd_idx]) begin
                  jab[cmd_idx] <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            // A fire is held back one slot so the final one can be marked.
            if (pend_valid) begin
              strobe     <= 1'b1;
              fired_slot <= SLOT_W'(pend_slot);
              last_fire  <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_slot  <= idx;
            if (keep) begin
              jab[idx] <= 1'b0;
            end else begin
              sched[idx] <= 1'b0;
              per[idx]   <= 1'b0;
              inf[idx]   <= 1'b0;
              jab[idx]   <= 1'b0;
            end
          end
          if (hit && step && again) begin
            state <= S_ADV;
          end else if (idx == LAST_IDX) begin
            state <= S_FLUSH;
          end else begin
            idx <= idx_inc;
          end
        end
        S_ADV: begin
          if (idx == LAST_IDX) begin
            state <= S_FLUSH;
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN;
          end
        end
        S_FLUSH: begin
          if (pend_valid) begin
            strobe     <= 1'b1;
            fired_slot <= SLOT_W'(pend_slot);
            last_fire  <= 1'b1;
          end
          pend_valid <= 1'b0;
          last_check <= current_time;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
